// ----- sv/amgiwu_pkg.sv -----
// Package for the AMG interpolation weight update block: word types,
// fixed-point widths, saturation limits and request codes.
// Depends on nothing.
`default_nettype none

package amgiwu_pkg;

   // Fixed-point format of matrix entries, weights and factors.
   localparam int VALUE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;
   // Running sums are magnitudes with 16 bits of headroom.
   localparam int SUM_BITS      = ((VALUE_WIDTH + 16) > 64) ? 64 : (VALUE_WIDTH + 16);
   localparam int ROW_WIDTH     = 10;
   // Row index widened to 17 bits, enough for table depths up to 2^17 rows.
   localparam int ROW_EXT_W     = 17;
   localparam int DEF_MAX_FINE_ROWS = 1024;

   localparam logic [VALUE_WIDTH-1:0] POS_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] NEG_MAX = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [SUM_BITS-1:0]    SUM_NEG_LIM = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic [SUM_BITS-1:0]    SUM_POS_LIM = {1'b0, {(SUM_BITS-1){1'b1}}};

   // Request codes carried in the func field.
   localparam logic FUNC_ENTRY  = 1'b0;
   localparam logic FUNC_WEIGHT = 1'b1;

   typedef struct packed {
      logic                          func;
      logic signed [VALUE_WIDTH-1:0] entry_value;
      logic                          is_diagonal;
      logic                          neighbor_is_coarse;
      logic                          row_last;
      logic [ROW_WIDTH-1:0]          fine_row;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] scaled_weight;
      logic                          diag_zero;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- sv/amg_interpolation_weight_update.sv -----
// AMG direct-interpolation weight update: row sums, shared divider and
// weight rescaling. Depends on amgiwu_pkg and amgiwu_ram.
//
// Usage. The req channel carries one word per matrix entry of a fine row
// (func = entry) or per interpolation weight to rescale (func = weight).
// Entries of a row come in any order; the entry flagged row_last closes the
// row and stores its alpha/beta factors and zero-diagonal flag in a table
// indexed by fine_row. A weight word returns exactly one rsp word with the
// weight scaled by -alpha (negative weight) or -beta (positive weight).
// Sequence. A row_last entry runs four divisions, each a load, 64 restoring
// steps of the one shared compare/subtract unit and a finish, and then the
// table write; a division with a zero operand skips its steps. A weight goes
// through table read, one 32x32 multiply, saturate and result. The block
// takes a new word only when its sequencer is idle (req_stall low).
// Stall. The result sits in an output register; the next word is accepted
// while it waits. A finished weight whose result cannot enter the output
// register holds in its last step until rsp_stall drops.
// Reset. Synchronous reset clears the sums, the diagonal and the control
// state; the factor table is not cleared, so a weight must follow the
// commit of its own row.
`default_nettype none

module amg_interpolation_weight_update #(
   parameter int MAX_FINE_ROWS = amgiwu_pkg::DEF_MAX_FINE_ROWS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire amgiwu_pkg::req_word_type req_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output amgiwu_pkg::rsp_word_type      rsp_word
);

   import amgiwu_pkg::*;

   localparam int ADDR_W = $clog2(MAX_FINE_ROWS);
   localparam int RAM_W  = 2 * VALUE_WIDTH + 1;
   localparam int DIVN_W = SUM_BITS + FRACTION_BITS;   // dividend bits
   localparam int CNT_W  = $clog2(DIVN_W);
   localparam int REM_W  = SUM_BITS + 1;
   localparam int PROD_W = 2 * VALUE_WIDTH;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DIV_LOAD = 8'b0000_0010,
      ST_DIV_RUN  = 8'b0000_0100,
      ST_DIV_DONE = 8'b0000_1000,
      ST_WRITE    = 8'b0001_0000,
      ST_READ     = 8'b0010_0000,
      ST_MUL      = 8'b0100_0000,
      ST_FIN      = 8'b1000_0000
   } state_type;

   // The four divisions of a row commit, in order.
   typedef enum logic [1:0] {
      PH_ALPHA_RATIO = 2'd0,
      PH_ALPHA_SCALE = 2'd1,
      PH_BETA_RATIO  = 2'd2,
      PH_BETA_SCALE  = 2'd3
   } phase_type;

   // Saturating magnitude add: min(s + m, lim).
   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0]    s,
                                                   input logic [VALUE_WIDTH-1:0] m,
                                                   input logic [SUM_BITS-1:0]    lim);
      logic [SUM_BITS:0] t;
      t = {1'b0, s} + (SUM_BITS + 1)'(m);
      return (t > {1'b0, lim}) ? lim : t[SUM_BITS-1:0];
   endfunction

   // Control and accumulator state.
   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [SUM_BITS-1:0]   sum_all_neg_ff, sum_all_neg_in;
   logic [SUM_BITS-1:0]   sum_all_pos_ff, sum_all_pos_in;
   logic [SUM_BITS-1:0]   sum_str_neg_ff, sum_str_neg_in;
   logic [SUM_BITS-1:0]   sum_str_pos_ff, sum_str_pos_in;
   logic [VALUE_WIDTH-1:0] diag_ff, diag_in;
   logic                  out_valid_ff, out_valid_in;

   // Datapath registers.
   logic [ROW_WIDTH-1:0]   row_ff, row_in;
   logic                   wneg_ff, wneg_in;
   logic [VALUE_WIDTH-1:0] wmag_ff, wmag_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [DIVN_W-1:0]      dvd_ff, dvd_in;
   logic [DIVN_W-1:0]      quot_ff, quot_in;
   logic [SUM_BITS-1:0]    dsr_ff, dsr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] lim_ff, lim_in;
   logic [VALUE_WIDTH-1:0] ratio_ff, ratio_in;
   logic [VALUE_WIDTH-1:0] alpha_ff, alpha_in;
   logic [VALUE_WIDTH-1:0] beta_ff, beta_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   rneg_ff, rneg_in;
   logic                   dz_ff, dz_in;
   rsp_word_type           out_word_ff, out_word_in;

   // Handshake.
   logic req_accept;
   logic rsp_accept;

   // Combinational helpers.
   logic [VALUE_WIDTH-1:0] in_raw;
   logic                   in_neg;
   logic [VALUE_WIDTH-1:0] in_mag;
   logic                   d_neg;
   logic [VALUE_WIDTH-1:0] d_mag;
   logic                   row_in_range;
   logic [ROW_EXT_W-1:0]   row_wide;
   logic [ADDR_W-1:0]      row_addr;
   logic [SUM_BITS-1:0]    div_num;
   logic [SUM_BITS-1:0]    div_den;
   logic [VALUE_WIDTH-1:0] div_lim;
   logic [REM_W-1:0]       trial;
   logic                   trial_ge;
   logic [VALUE_WIDTH-1:0] q_sat;
   logic [VALUE_WIDTH-1:0] q_signed;
   logic [VALUE_WIDTH-1:0] coef;
   logic                   coef_neg;
   logic [VALUE_WIDTH-1:0] coef_mag;
   logic [PROD_W-1:0]      prod_shift;
   logic [VALUE_WIDTH-1:0] prod_lim;
   logic [VALUE_WIDTH-1:0] pmag;
   logic [VALUE_WIDTH-1:0] res_raw;
   logic                   res_dz;

   // Factor table: {diag_zero, alpha, beta} per fine row.
   logic             ram_we;
   logic [RAM_W-1:0] ram_wdata;
   logic [RAM_W-1:0] ram_rdata;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = out_valid_ff && !rsp_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_word   = out_word_ff;

   // Split the incoming value into sign and magnitude.
   assign in_raw = req_word.entry_value;
   assign in_neg = in_raw[VALUE_WIDTH-1];
   assign in_mag = in_neg ? (~in_raw + VALUE_WIDTH'(1)) : in_raw;

   assign d_neg = diag_ff[VALUE_WIDTH-1];
   assign d_mag = d_neg ? (~diag_ff + VALUE_WIDTH'(1)) : diag_ff;

   // Rows past the table depth store nothing and answer zero.
   assign row_in_range = (32'(row_ff) < 32'(MAX_FINE_ROWS));
   assign row_wide     = ROW_EXT_W'(row_ff);
   assign row_addr     = row_wide[ADDR_W-1:0];

   // Operand select for the division in flight.
   always_comb begin
      unique case (phase_ff)
         PH_ALPHA_RATIO: begin
            div_num = sum_all_neg_ff;
            div_den = sum_str_neg_ff;
            div_lim = POS_MAX;
         end
         PH_ALPHA_SCALE: begin
            div_num = SUM_BITS'(ratio_ff);
            div_den = SUM_BITS'(d_mag);
            div_lim = d_neg ? NEG_MAX : POS_MAX;
         end
         PH_BETA_RATIO: begin
            div_num = sum_all_pos_ff;
            div_den = sum_str_pos_ff;
            div_lim = POS_MAX;
         end
         PH_BETA_SCALE: begin
            div_num = SUM_BITS'(ratio_ff);
            div_den = SUM_BITS'(d_mag);
            div_lim = d_neg ? NEG_MAX : POS_MAX;
         end
         default: begin
            div_num = '0;
            div_den = '0;
            div_lim = POS_MAX;
         end
      endcase
   end

   // Shared restoring step: shift in one dividend bit, compare, subtract.
   assign trial    = {rem_ff[REM_W-2:0], dvd_ff[DIVN_W-1]};
   assign trial_ge = (trial >= {1'b0, dsr_ff});

   // Clamp the quotient and give the scale factor the diagonal's sign.
   assign q_sat    = (quot_ff > DIVN_W'(lim_ff)) ? lim_ff : quot_ff[VALUE_WIDTH-1:0];
   assign q_signed = (d_neg && (q_sat != '0)) ? (~q_sat + VALUE_WIDTH'(1)) : q_sat;

   // Pick alpha for a negative weight, beta for a positive one.
   assign coef     = wneg_ff ? ram_rdata[2*VALUE_WIDTH-1:VALUE_WIDTH]
                             : ram_rdata[VALUE_WIDTH-1:0];
   assign coef_neg = coef[VALUE_WIDTH-1];
   assign coef_mag = coef_neg ? (~coef + VALUE_WIDTH'(1)) : coef;

   // Drop the fraction bits, saturate, and apply the result sign.
   assign prod_shift = prod_ff >> FRACTION_BITS;
   assign prod_lim   = rneg_ff ? NEG_MAX : POS_MAX;
   assign pmag       = (prod_shift > PROD_W'(prod_lim)) ? prod_lim
                                                        : prod_shift[VALUE_WIDTH-1:0];

   always_comb begin
      priority if (!row_in_range || (wmag_ff == '0)) begin
         res_raw = '0;
         res_dz  = 1'b0;
      end else if (dz_ff) begin
         // Zero diagonal: full scale, opposite sign to the weight.
         res_raw = wneg_ff ? POS_MAX : NEG_MAX;
         res_dz  = 1'b1;
      end else begin
         res_raw = (rneg_ff && (pmag != '0)) ? (~pmag + VALUE_WIDTH'(1)) : pmag;
         res_dz  = 1'b0;
      end
   end

   assign ram_wdata = {(d_mag == '0), alpha_ff, beta_ff};

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      sum_all_neg_in = sum_all_neg_ff;
      sum_all_pos_in = sum_all_pos_ff;
      sum_str_neg_in = sum_str_neg_ff;
      sum_str_pos_in = sum_str_pos_ff;
      diag_in        = diag_ff;
      out_valid_in   = out_valid_ff && !rsp_accept;
      row_in         = row_ff;
      wneg_in        = wneg_ff;
      wmag_in        = wmag_ff;
      rem_in         = rem_ff;
      dvd_in         = dvd_ff;
      quot_in        = quot_ff;
      dsr_in         = dsr_ff;
      cnt_in         = cnt_ff;
      lim_in         = lim_ff;
      ratio_in       = ratio_ff;
      alpha_in       = alpha_ff;
      beta_in        = beta_ff;
      prod_in        = prod_ff;
      rneg_in        = rneg_ff;
      dz_in          = dz_ff;
      out_word_in    = out_word_ff;
      ram_we         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               row_in = req_word.fine_row;
               if (req_word.func == FUNC_WEIGHT) begin
                  wneg_in  = in_neg;
                  wmag_in  = in_mag;
                  state_in = ST_READ;
               end else begin
                  // Diagonal sets the divisor; other nonzero entries add
                  // their magnitude to the sums of their sign.
                  if (req_word.is_diagonal) begin
                     diag_in = in_raw;
                  end else if (in_mag != '0) begin
                     if (in_neg) begin
                        sum_all_neg_in = sat_add(sum_all_neg_ff, in_mag, SUM_NEG_LIM);
                        if (req_word.neighbor_is_coarse) begin
                           sum_str_neg_in = sat_add(sum_str_neg_ff, in_mag, SUM_NEG_LIM);
                        end
                     end else begin
                        sum_all_pos_in = sat_add(sum_all_pos_ff, in_mag, SUM_POS_LIM);
                        if (req_word.neighbor_is_coarse) begin
                           sum_str_pos_in = sat_add(sum_str_pos_ff, in_mag, SUM_POS_LIM);
                        end
                     end
                  end
                  if (req_word.row_last) begin
                     phase_in = PH_ALPHA_RATIO;
                     state_in = ST_DIV_LOAD;
                  end
               end
            end
         end

         ST_DIV_LOAD: begin
            rem_in  = '0;
            quot_in = '0;
            dvd_in  = {div_num, {FRACTION_BITS{1'b0}}};
            dsr_in  = div_den;
            lim_in  = div_lim;
            cnt_in  = CNT_W'(DIVN_W - 1);
            // Zero strong sum or zero diagonal gives a zero factor;
            // a zero numerator gives a zero quotient. Skip the steps.
            if ((div_den == '0) || (d_mag == '0) || (div_num == '0)) begin
               state_in = ST_DIV_DONE;
            end else begin
               state_in = ST_DIV_RUN;
            end
         end

         ST_DIV_RUN: begin
            rem_in  = trial_ge ? (trial - {1'b0, dsr_ff}) : trial;
            quot_in = {quot_ff[DIVN_W-2:0], trial_ge};
            dvd_in  = {dvd_ff[DIVN_W-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DIV_DONE;
            end
         end

         ST_DIV_DONE: begin
            state_in = ST_DIV_LOAD;
            unique case (phase_ff)
               PH_ALPHA_RATIO: begin
                  ratio_in = q_sat;
                  phase_in = PH_ALPHA_SCALE;
               end
               PH_ALPHA_SCALE: begin
                  alpha_in = q_signed;
                  phase_in = PH_BETA_RATIO;
               end
               PH_BETA_RATIO: begin
                  ratio_in = q_sat;
                  phase_in = PH_BETA_SCALE;
               end
               PH_BETA_SCALE: begin
                  beta_in  = q_signed;
                  state_in = ST_WRITE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_WRITE: begin
            // Store the factors and start the next row from clean sums.
            ram_we         = row_in_range;
            sum_all_neg_in = '0;
            sum_all_pos_in = '0;
            sum_str_neg_in = '0;
            sum_str_pos_in = '0;
            state_in       = ST_IDLE;
         end

         ST_READ: begin
            // Table address is presented this cycle; data lands next cycle.
            state_in = ST_MUL;
         end

         ST_MUL: begin
            // 32x32 magnitude product, registered before the shift.
            prod_in  = PROD_W'(coef_mag) * PROD_W'(wmag_ff);
            rneg_in  = (coef_neg == wneg_ff);
            dz_in    = ram_rdata[RAM_W-1];
            state_in = ST_FIN;
         end

         ST_FIN: begin
            // Hold here while the output register still carries a word.
            if (!out_valid_ff || rsp_accept) begin
               out_word_in.scaled_weight = res_raw;
               out_word_in.diag_zero     = res_dz;
               out_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_ALPHA_RATIO;
         sum_all_neg_ff <= '0;
         sum_all_pos_ff <= '0;
         sum_str_neg_ff <= '0;
         sum_str_pos_ff <= '0;
         diag_ff        <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         sum_all_neg_ff <= sum_all_neg_in;
         sum_all_pos_ff <= sum_all_pos_in;
         sum_str_neg_ff <= sum_str_neg_in;
         sum_str_pos_ff <= sum_str_pos_in;
         diag_ff        <= diag_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      wneg_ff     <= wneg_in;
      wmag_ff     <= wmag_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quot_ff     <= quot_in;
      dsr_ff      <= dsr_in;
      cnt_ff      <= cnt_in;
      lim_ff      <= lim_in;
      ratio_ff    <= ratio_in;
      alpha_ff    <= alpha_in;
      beta_ff     <= beta_in;
      prod_ff     <= prod_in;
      rneg_ff     <= rneg_in;
      dz_ff       <= dz_in;
      out_word_ff <= out_word_in;
   end

   amgiwu_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_FINE_ROWS)
   ) u_factor_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (row_addr),
      .wr_data (ram_wdata),
      .rd_addr (row_addr),
      .rd_data (ram_rdata)
   );

   // A strong sum only ever collects entries that the matching total collects.
   a_strong_le_all: assert property (@(posedge clock) disable iff (reset)
      (sum_str_neg_ff <= sum_all_neg_ff) && (sum_str_pos_ff <= sum_all_pos_ff))
      else $error("strong sum exceeds total sum");

   // Sums never pass their saturation limits.
   a_sum_limits: assert property (@(posedge clock) disable iff (reset)
      (sum_all_neg_ff <= SUM_NEG_LIM) && (sum_all_pos_ff <= SUM_POS_LIM))
      else $error("row sum beyond saturation limit");

   // A commit leaves clean sums for the next row.
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> (sum_all_neg_ff == '0) && (sum_all_pos_ff == '0) &&
                                 (sum_str_neg_ff == '0) && (sum_str_pos_ff == '0))
      else $error("sums not cleared after commit");

   // A zero-diagonal result is always full scale.
   a_diag_zero_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.diag_zero) |->
         ((rsp_word.scaled_weight == POS_MAX) || (rsp_word.scaled_weight == NEG_MAX)))
      else $error("diag_zero result not saturated");

   // A weight word goes straight to the table read.
   a_weight_reads: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_word.func == FUNC_WEIGHT)) |=> (state_ff == ST_READ))
      else $error("weight word did not start a table read");

endmodule

`default_nettype wire

// ----- sv/amgiwu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module amgiwu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
